// ----- sv/ssm_pkg.sv -----
// Shared types and constants for the substring search matcher.
// No dependencies; every module of the block imports this package.
package ssm_pkg;

  typedef logic [7:0] byte_t;

  // command codes on the request channel
  localparam logic [1:0] CMD_PATTERN = 2'd0;
  localparam logic [1:0] CMD_TEXT    = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;

  localparam int OFF_W       = 13;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [OFF_W-1:0] offset_t;

  typedef struct packed {
    logic [1:0] command;
    byte_t      data_byte;
    logic       pattern_first;
  } ssm_in_t;

  typedef struct packed {
    logic    found;
    offset_t match_offset;
    logic    pattern_overflow;
    logic    text_overflow;
  } ssm_out_t;

  typedef enum logic [1:0] {
    OP_PATTERN,
    OP_TEXT,
    OP_END
  } ssm_op_e;

  // classified request as it travels through the queue
  typedef struct packed {
    ssm_op_e op;
    byte_t   data_byte;
    logic    restart;
  } ssm_op_t;

  // side information that follows a request down the compare pipeline
  typedef struct packed {
    logic is_end;
    logic ok;
    logic empty;
    logic pdrop;
    logic tdrop;
  } ssm_tag_t;

endpackage

// ----- sv/ssm_stream_if.sv -----
// Valid/ready stream interface with a payload of any packed type.
// Used for the request, result and internal queue channels.
interface ssm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ssm_front.sv -----
// Front end: registers each request, drops unknown commands, classifies the rest.
// Depends on ssm_pkg and ssm_stream_if.
module ssm_front import ssm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssm_stream_if.sink   req_i,
  ssm_stream_if.source op_o
);

  logic    hold_vld_q;
  ssm_op_t hold_q;
  ssm_op_t op_d;
  logic    keep;
  logic    take;

  assign req_i.ready = !hold_vld_q || op_o.ready;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    op_d.data_byte = req_i.data.data_byte;
    op_d.restart   = req_i.data.pattern_first;
    op_d.op        = OP_PATTERN;
    keep           = 1'b1;
    unique case (req_i.data.command)
      CMD_PATTERN: op_d.op = OP_PATTERN;
      CMD_TEXT:    op_d.op = OP_TEXT;
      CMD_END:     op_d.op = OP_END;
      default:     keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else begin
      if (op_o.ready) begin
        hold_vld_q <= 1'b0;
      end
      if (take && keep) begin
        hold_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && keep) begin
      hold_q <= op_d;
    end
  end

  assign op_o.valid = hold_vld_q;
  assign op_o.data  = hold_q;

endmodule

// ----- sv/ssm_queue.sv -----
// Short request queue between the front end and the compare back end.
// Depends on ssm_pkg and ssm_stream_if.
module ssm_queue import ssm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssm_stream_if.sink   in_i,
  ssm_stream_if.source out_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ssm_op_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign in_i.ready  = count_q < CNT_W'(QUEUE_DEPTH);
  assign out_o.valid = count_q != '0;
  assign out_o.data  = mem_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = out_o.valid && out_o.ready;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.data;
    end
  end

endmodule

// ----- sv/ssm_back.sv -----
// Back end: pattern and text window cells, pipelined compare and result register.
// Depends on ssm_pkg and ssm_stream_if.
module ssm_back import ssm_pkg::*; #(
  parameter int MAX_PATTERN = 128,
  parameter int MAX_TEXT    = 8192
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssm_stream_if.sink   op_i,
  ssm_stream_if.source rsp_o
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W = $clog2(MAX_TEXT + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int GRP_W = 16;
  localparam int NGRP  = (MAX_PATTERN + GRP_W - 1) / GRP_W;
  localparam int PAD_W = NGRP * GRP_W;

  // cell i of the pattern holds pattern byte (length - 1 - i), cell i of the
  // window holds the text byte of age i, so cells line up without indexing
  byte_t            pat_q [MAX_PATTERN];
  byte_t            win_q [MAX_PATTERN];
  byte_t            win_n [MAX_PATTERN];
  logic [LEN_W-1:0] len_q, len_d, len_base;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pdrop_q, pdrop_d, tdrop_q, tdrop_d;
  logic             shift_pat, shift_win;

  logic             s1_vld_q, s1_vld_d;
  ssm_tag_t         s1_tag_q, s1_tag_d;
  logic [PAD_W-1:0] s1_eq_q, eq_d;
  logic [CNT_W-1:0] s1_off_q, off_d;

  logic             s2_vld_q;
  ssm_tag_t         s2_tag_q;
  logic [NGRP-1:0]  s2_grp_q, grp_d;
  logic [CNT_W-1:0] s2_off_q;

  logic             match_q;
  logic [CNT_W-1:0] first_q;
  logic             out_vld_q;
  ssm_out_t         out_q;

  logic             adv, pop, hit;
  ssm_op_t          op;
  logic [CMP_W-1:0] cnt_ext, len_ext;

  // hold the whole pipeline while a result waits to be taken
  assign adv        = !out_vld_q || rsp_o.ready;
  assign op_i.ready = adv;
  assign pop        = adv && op_i.valid;
  assign op         = op_i.data;

  always_comb begin
    len_base  = len_q;
    len_d     = len_q;
    pdrop_d   = pdrop_q;
    cnt_d     = cnt_q;
    tdrop_d   = tdrop_q;
    shift_pat = 1'b0;
    shift_win = 1'b0;
    s1_vld_d  = 1'b0;
    s1_tag_d  = '0;
    if (pop) begin
      unique case (op.op)
        OP_PATTERN: begin
          if (op.restart) begin
            len_base = '0;
            pdrop_d  = 1'b0;
          end
          len_d = len_base;
          if (CMP_W'(len_base) < CMP_W'(MAX_PATTERN)) begin
            shift_pat = 1'b1;
            len_d     = len_base + 1'b1;
          end else begin
            pdrop_d = 1'b1;
          end
        end
        OP_TEXT: begin
          if (CMP_W'(cnt_q) >= CMP_W'(MAX_TEXT)) begin
            tdrop_d = 1'b1;
          end else begin
            shift_win = 1'b1;
            cnt_d     = cnt_q + 1'b1;
            s1_vld_d  = 1'b1;
          end
        end
        OP_END: begin
          cnt_d          = '0;
          tdrop_d        = 1'b0;
          s1_vld_d       = 1'b1;
          s1_tag_d.is_end = 1'b1;
          s1_tag_d.empty = len_q == '0;
          s1_tag_d.pdrop = pdrop_q;
          s1_tag_d.tdrop = tdrop_q;
        end
        default: ;
      endcase
    end
    cnt_ext     = CMP_W'(cnt_d);
    len_ext     = CMP_W'(len_q);
    off_d       = CNT_W'(cnt_ext - len_ext);
    if (!s1_tag_d.is_end) begin
      s1_tag_d.ok = (len_q != '0) && (cnt_ext >= len_ext);
    end
  end

  always_comb begin
    win_n[0] = op.data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_n[i] = win_q[i-1];
    end
    eq_d = '1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq_d[i] = (CMP_W'(i) >= CMP_W'(len_q)) || (win_n[i] == pat_q[i]);
    end
  end

  always_comb begin
    for (int k = 0; k < NGRP; k++) begin
      grp_d[k] = &s1_eq_q[k*GRP_W +: GRP_W];
    end
  end

  assign hit = s2_vld_q && !s2_tag_q.is_end && s2_tag_q.ok && (&s2_grp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      pdrop_q   <= 1'b0;
      cnt_q     <= '0;
      tdrop_q   <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      match_q   <= 1'b0;
      first_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      pdrop_q <= pdrop_d;
      cnt_q   <= cnt_d;
      tdrop_q <= tdrop_d;
      if (adv) begin
        s1_vld_q  <= s1_vld_d;
        s2_vld_q  <= s1_vld_q;
        out_vld_q <= s2_vld_q && s2_tag_q.is_end;
        if (s2_vld_q && s2_tag_q.is_end) begin
          match_q <= 1'b0;
          first_q <= '0;
        end else if (hit && !match_q) begin
          match_q <= 1'b1;
          first_q <= s2_off_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_pat) begin
      pat_q[0] <= op.data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        pat_q[i] <= pat_q[i-1];
      end
    end
    if (shift_win) begin
      win_q <= win_n;
    end
    if (adv) begin
      s1_tag_q <= s1_tag_d;
      s1_eq_q  <= eq_d;
      s1_off_q <= off_d;
      s2_tag_q <= s1_tag_q;
      s2_grp_q <= grp_d;
      s2_off_q <= s1_off_q;
      if (s2_vld_q && s2_tag_q.is_end) begin
        out_q.found            <= match_q || s2_tag_q.empty;
        out_q.match_offset     <= match_q ? OFF_W'(first_q) : '0;
        out_q.pattern_overflow <= s2_tag_q.pdrop;
        out_q.text_overflow    <= s2_tag_q.tdrop;
      end
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

endmodule

// ----- sv/substring_search_matcher.sv -----
// Substring search matcher: load a pattern of up to MAX_PATTERN bytes, stream
// up to MAX_TEXT text bytes, then send an end item to get one result with the
// offset of the first match. Requests are registered in the front end and in
// the queue, so pattern and text bytes flow at one per cycle unless the back end
// holds; each text byte is compared against the whole pattern in parallel window
// cells, and the compare runs through a three-stage pipeline (cell compare, group
// AND, final AND) into the result register. The back end holds while a result
// waits on the output, and the four-entry queue then fills before requests are
// refused. No clearing pass is needed after reset.
// Depends on ssm_pkg, ssm_stream_if, ssm_front, ssm_queue and ssm_back.
module substring_search_matcher import ssm_pkg::*; #(
  parameter int MAX_PATTERN = 128,
  parameter int MAX_TEXT    = 8192
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssm_stream_if.sink   req_i,
  ssm_stream_if.source rsp_o
);

  ssm_stream_if #(.T(ssm_op_t)) fq_if ();
  ssm_stream_if #(.T(ssm_op_t)) qb_if ();

  ssm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .op_o   (fq_if)
  );

  ssm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (fq_if),
    .out_o  (qb_if)
  );

  ssm_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (qb_if),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- verif/ssm_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the substring search matcher: tracks pattern and text state
// from accepted requests and checks each result against the oldest pending one.
// Depends on ssm_pkg.
module ssm_checker import ssm_pkg::*; #(
  parameter int MAX_PATTERN = 128,
  parameter int MAX_TEXT    = 8192
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_ready_i,
  input  ssm_in_t  req_data_i,
  input  logic     rsp_valid_i,
  input  logic     rsp_ready_i,
  input  ssm_out_t rsp_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  byte_t    pattern_bytes [MAX_PATTERN];
  int       pattern_len;
  byte_t    window [MAX_PATTERN];  // window[0] holds the newest text byte
  int       text_len;
  logic     hit_seen;
  offset_t  hit_offset;
  logic     pattern_lost;
  logic     text_lost;
  ssm_out_t pending_reports [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic clear_text();
    foreach (window[i]) window[i] = '0;
    text_len   = 0;
    hit_seen   = 1'b0;
    hit_offset = '0;
    text_lost  = 1'b0;
  endtask

  function automatic logic window_hit();
    if (pattern_len == 0 || text_len < pattern_len) return 1'b0;
    for (int j = 0; j < pattern_len; j++) begin
      if (pattern_bytes[j] != window[pattern_len - 1 - j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic search_step(input ssm_in_t r);
    ssm_out_t report;
    case (r.command)
      CMD_PATTERN: begin
        if (r.pattern_first) begin
          pattern_len  = 0;
          pattern_lost = 1'b0;
        end
        if (pattern_len < MAX_PATTERN) begin
          pattern_bytes[pattern_len] = r.data_byte;
          pattern_len++;
        end else begin
          pattern_lost = 1'b1;
        end
      end
      CMD_TEXT: begin
        if (text_len >= MAX_TEXT) begin
          text_lost = 1'b1;
        end else begin
          for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i - 1];
          window[0] = r.data_byte;
          text_len++;
          // only the first ending position that matches counts
          if (!hit_seen && window_hit()) begin
            hit_seen   = 1'b1;
            hit_offset = offset_t'(text_len - pattern_len);
          end
        end
      end
      CMD_END: begin
        report.found            = hit_seen || (pattern_len == 0);
        report.match_offset     = hit_seen ? hit_offset : '0;
        report.pattern_overflow = pattern_lost;
        report.text_overflow    = text_lost;
        pending_reports.push_back(report);
        clear_text();
      end
      default: ;
    endcase
  endtask

  task automatic check_report(input ssm_out_t got);
    ssm_out_t want;
    if (pending_reports.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected result found=%0b offset=%0d povf=%0b tovf=%0b",
                 $time, got.found, got.match_offset, got.pattern_overflow,
                 got.text_overflow);
      return;
    end
    want = pending_reports.pop_front();
    if (got.found != want.found || got.match_offset != want.match_offset ||
        got.pattern_overflow != want.pattern_overflow ||
        got.text_overflow != want.text_overflow) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: result mismatch: expected found=%0b offset=%0d povf=%0b tovf=%0b, got found=%0b offset=%0d povf=%0b tovf=%0b",
                 $time, want.found, want.match_offset, want.pattern_overflow,
                 want.text_overflow, got.found, got.match_offset,
                 got.pattern_overflow, got.text_overflow);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
      pattern_len  = 0;
      pattern_lost = 1'b0;
      clear_text();
      pending_reports.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) check_report(rsp_data_i);
      if (req_valid_i && req_ready_i) search_step(req_data_i);
    end
    pending_o = pending_reports.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Top of the substring search matcher testbench: clock, reset, request
// stimulus, result back-pressure and the verdict. Depends on ssm_pkg,
// ssm_stream_if, the matcher and ssm_checker.
module testbench import ssm_pkg::*;;

  localparam int         MAX_PATTERN = 128;
  localparam int         MAX_TEXT    = 8192;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic  clk_i;
  logic  rst_ni;
  int    fail_count;
  int    pending_n;
  int    burst_left = 0;
  int    sent_items = 0;
  bit    hold_rsp   = 1'b0;
  bit    narrow     = 1'b0;
  byte_t alphabet [2];
  byte_t loaded_pattern [$];

  ssm_stream_if #(.T(ssm_in_t))  req_if ();
  ssm_stream_if #(.T(ssm_out_t)) rsp_if ();

  substring_search_matcher #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_TEXT   (MAX_TEXT)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  ssm_checker #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_TEXT   (MAX_TEXT)
  ) scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_data_i  (rsp_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending_n)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

  // result side: random stall modes, plus one long hold-off on demand
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_rsp = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= ($urandom_range(0, 1) == 0);
        default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_req(input logic [1:0] cmd, input byte_t b, input logic first);
    ssm_in_t item;
    item.command       = cmd;
    item.data_byte     = b;
    item.pattern_first = first;
    if (burst_left <= 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    if (cmd != CMD_UNKNOWN) sent_items++;
  endtask

  task automatic send_end();
    send_req(CMD_END, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic pause_until_drained();
    req_if.valid <= 1'b0;
    wait (pending_n == 0);
    @(negedge clk_i);
  endtask

  function automatic byte_t pick_byte();
    if (narrow) return alphabet[$urandom_range(0, 1)];
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic int pattern_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 6);
    if (r < 93) return $urandom_range(7, 40);
    if (r < 97) return $urandom_range(120, MAX_PATTERN);
    return $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
  endfunction

  task automatic load_pattern(input int len, input logic restart);
    byte_t b;
    if (restart) loaded_pattern.delete();
    for (int i = 0; i < len; i++) begin
      b = pick_byte();
      send_req(CMD_PATTERN, b, restart && i == 0);
      if (loaded_pattern.size() < MAX_PATTERN) loaded_pattern.push_back(b);
    end
  endtask

  // random text, now and then with a copy of the current pattern dropped in
  task automatic send_text(input int len, input bit may_plant);
    int sent;
    sent = 0;
    while (sent < len) begin
      if (may_plant && loaded_pattern.size() > 0 && $urandom_range(0, 5) == 0) begin
        foreach (loaded_pattern[i]) send_req(CMD_TEXT, loaded_pattern[i], 1'b0);
        sent += loaded_pattern.size();
      end else begin
        send_req(CMD_TEXT, pick_byte(), $urandom_range(0, 7) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    int    kind;
    bit    hold_done;
    bit    drain_done;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty pattern matches at offset zero, with and without text
    send_end();
    send_req(CMD_TEXT, 8'h00, 1'b0);
    send_req(CMD_TEXT, 8'hFF, 1'b1);
    send_end();
    send_req(CMD_UNKNOWN, 8'hFF, 1'b1);
    // first pattern bytes after reset append without a restart
    send_req(CMD_PATTERN, 8'hFF, 1'b0);
    send_req(CMD_PATTERN, 8'h00, 1'b0);
    // pattern longer than the text
    send_req(CMD_TEXT, 8'hFF, 1'b0);
    send_end();
    send_req(CMD_TEXT, 8'h00, 1'b0);
    send_req(CMD_TEXT, 8'hFF, 1'b0);
    send_req(CMD_TEXT, 8'h00, 1'b0);
    send_end();
    // swap the pattern mid-text: earlier positions are not rechecked
    send_req(CMD_PATTERN, 8'h5A, 1'b1);
    send_req(CMD_TEXT, 8'h3C, 1'b0);
    send_req(CMD_TEXT, 8'h3C, 1'b0);
    send_req(CMD_PATTERN, 8'h3C, 1'b1);
    send_req(CMD_TEXT, 8'h11, 1'b0);
    send_end();
    send_req(CMD_TEXT, 8'h3C, 1'b0);
    send_end();

    sent_items = 0;
    // full pattern and an overflowing one, each with a planted match
    narrow = 1'b0;
    load_pattern(MAX_PATTERN + 3, 1'b1);
    send_text(10, 1'b0);
    foreach (loaded_pattern[i]) send_req(CMD_TEXT, loaded_pattern[i], 1'b0);
    send_end();
    load_pattern(MAX_PATTERN, 1'b1);
    send_text(5, 1'b0);
    foreach (loaded_pattern[i]) send_req(CMD_TEXT, loaded_pattern[i], 1'b0);
    send_end();

    while (sent_items < 1550) begin
      if (!hold_done && sent_items >= 700) begin
        hold_rsp   = 1'b1;
        burst_left = 400;
        hold_done  = 1'b1;
      end
      if (!drain_done && sent_items >= 1100) begin
        pause_until_drained();
        drain_done = 1'b1;
      end
      if ($urandom_range(0, 1) == 0 || loaded_pattern.size() == 0) begin
        narrow      = ($urandom_range(0, 3) != 0);
        alphabet[0] = byte_t'($urandom_range(0, 255));
        alphabet[1] = byte_t'($urandom_range(0, 255));
        load_pattern(pattern_size(), 1'b1);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          send_text($urandom_range(0, 15), 1'b1);
          load_pattern($urandom_range(1, 4), 1'($urandom_range(0, 1)));
          send_text($urandom_range(0, 20), 1'b1);
          send_end();
        end
        1: begin
          send_text($urandom_range(0, loaded_pattern.size() - 1), 1'b0);
          send_end();
        end
        2: begin
          repeat ($urandom_range(1, 4))
            send_req(CMD_UNKNOWN, byte_t'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
          send_text($urandom_range(0, 8), 1'b1);
          send_end();
        end
        default: begin
          send_text($urandom_range(0, 24), 1'b1);
          send_end();
        end
      endcase
    end

    pause_until_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ssm_pkg.sv
sv/ssm_stream_if.sv
sv/ssm_front.sv
sv/ssm_queue.sv
sv/ssm_back.sv
sv/substring_search_matcher.sv
verif/ssm_checker.sv
verif/testbench.sv
